@@ src/lrukr_pkg.sv @@
package lrukr_pkg;

	// sizes
	localparam int FRAME_SLOTS = 64;
	localparam int FRAME_W     = $clog2(FRAME_SLOTS);
	localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
	localparam int COUNT_W     = 4;
	localparam int STAMP_W     = 32;
	localparam int K_W         = 4;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_K_VALUE       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'b1;

	// reset values and limits
	localparam logic [K_W-1:0]     K_RESET   = K_W'(2);
	localparam logic [CNT_W-1:0]   FIU_RESET = CNT_W'(FRAME_SLOTS);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_SET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_EVICT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NONE    = 2'd1,
		ST_INVALID = 2'd2,
		ST_PINNED  = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [FRAME_W-1:0] frame;
		logic             make_evictable;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [FRAME_W-1:0] victim;
		logic [CNT_W-1:0] evictable_count;
	} rsp_t;

	// one word of the frame store
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// one scanned slot handed to the victim selector
	typedef struct packed {
		logic               clear;
		logic               valid;
		logic [FRAME_W-1:0] idx;
		logic               eligible;
		logic               in_cache;
		logic [STAMP_W-1:0] stamp;
	} scan_entry_t;

	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] idx;
	} pick_t;

endpackage

@@ src/lru_k_frame_replacer.sv @@
// record, set evictable and remove: frame modified in S_MOD, response registered in S_RESP once the output is free
// evict: response registered after the scan of the 64-entry stamp memory at one read per
// cycle, then S_SCAN_LAST, S_PICK and S_RESP; one request in flight at a time
// reset clears tracked and evictable flags, counters and stamp clock at once;
// the stamp memory has no clearing pass and its data are used only for tracked frames
module lru_k_frame_replacer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  lrukr_pkg::req_t                 req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output lrukr_pkg::rsp_t                 rsp,
	input  logic                            cfg_we,
	input  logic [lrukr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lrukr_pkg::CFG_W-1:0]     cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_MOD       = 6'b000010,
		S_SCAN      = 6'b000100,
		S_SCAN_LAST = 6'b001000,
		S_PICK      = 6'b010000,
		S_RESP      = 6'b100000
	} state_t;

	localparam logic [lrukr_pkg::FRAME_W-1:0] LAST_FRAME =
		lrukr_pkg::FRAME_W'(lrukr_pkg::FRAME_SLOTS - 1);

	state_t                            state_q;
	logic [lrukr_pkg::FRAME_W-1:0]     idx_q;
	logic [lrukr_pkg::FRAME_SLOTS-1:0] tracked_q, evict_q;
	logic [lrukr_pkg::CNT_W-1:0]       tracked_total_q, evict_total_q;
	logic [lrukr_pkg::STAMP_W-1:0]     stamp_q;
	logic [lrukr_pkg::K_W-1:0]         k_q;
	logic [lrukr_pkg::CNT_W-1:0]       fiu_q;
	logic                              rsp_valid_q;
	lrukr_pkg::req_t                   req_q;
	lrukr_pkg::rsp_t                   res_q, rsp_q;
	logic [lrukr_pkg::FRAME_W-1:0]     idx_s1;
	logic                              vld_s1;

	logic                              accept, rsp_free;
	logic [lrukr_pkg::K_W-1:0]         keff;
	logic [lrukr_pkg::FRAME_W-1:0]     raddr;
	lrukr_pkg::entry_t                 rdata, wdata;
	logic                              mem_we;
	lrukr_pkg::scan_entry_t            scan_ent;
	lrukr_pkg::pick_t                  hist, cache;

	// modify results for record, set and remove
	lrukr_pkg::status_t                mod_status;
	logic                              mod_trk, mod_ev, mod_adv, mod_we;
	logic [lrukr_pkg::CNT_W-1:0]       mod_ttot, mod_etot;
	logic [lrukr_pkg::COUNT_W-1:0]     cnt;
	logic                              trk, ce, bad;

	// pick results for evict
	logic                              pick_any;
	logic [lrukr_pkg::FRAME_W-1:0]     pick_v;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign keff      = (k_q == '0) ? lrukr_pkg::K_W'(1) : k_q;

	// memory read address: request frame at accept, scan index otherwise
	assign raddr = (state_q == S_IDLE) ? req.frame : idx_q;

	lrukr_frame_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (req_q.frame),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// scan slot presented to the selector in the cycle after its read
	always_comb begin
		scan_ent.clear    = accept && (req.op == lrukr_pkg::OP_EVICT);
		scan_ent.valid    = vld_s1;
		scan_ent.idx      = idx_s1;
		scan_ent.eligible = tracked_q[idx_s1] && evict_q[idx_s1];
		scan_ent.in_cache = (rdata.count >= keff);
		scan_ent.stamp    = rdata.stamp;
	end

	lrukr_victim_sel u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.ent    (scan_ent),
		.hist   (hist),
		.cache  (cache)
	);

	// read-modify-write of one frame; the next request cannot overlap the write
	always_comb begin
		trk        = tracked_q[req_q.frame];
		ce         = evict_q[req_q.frame];
		bad        = ({1'b0, req_q.frame} >= fiu_q);
		mod_status = lrukr_pkg::ST_OK;
		mod_trk    = trk;
		mod_ev     = ce;
		mod_ttot   = tracked_total_q;
		mod_etot   = evict_total_q;
		mod_adv    = 1'b0;
		mod_we     = 1'b0;
		wdata      = rdata;
		cnt        = rdata.count;
		if (bad) begin
			mod_status = lrukr_pkg::ST_INVALID;
		end else begin
			case (req_q.op)
				lrukr_pkg::OP_RECORD: begin
					if (!trk) begin
						if (tracked_total_q >= fiu_q) begin
							mod_status = lrukr_pkg::ST_INVALID;
						end else begin
							mod_trk     = 1'b1;
							mod_ev      = 1'b1;
							mod_ttot    = tracked_total_q + 1'b1;
							mod_etot    = evict_total_q + 1'b1;
							mod_we      = 1'b1;
							mod_adv     = 1'b1;
							wdata.count = lrukr_pkg::COUNT_W'(1);
							wdata.stamp = stamp_q;
						end
					end else begin
						if ((cnt < keff) && (cnt != lrukr_pkg::COUNT_MAX)) begin
							cnt = cnt + 1'b1;
						end
						wdata.count = cnt;
						mod_we      = 1'b1;
						if (cnt >= keff) begin
							wdata.stamp = stamp_q;
							mod_adv     = 1'b1;
						end
					end
				end
				lrukr_pkg::OP_SET: begin
					if (trk) begin
						if (ce && !req_q.make_evictable) begin
							mod_ev = 1'b0;
							if (evict_total_q != '0) mod_etot = evict_total_q - 1'b1;
						end else if (!ce && req_q.make_evictable) begin
							mod_ev   = 1'b1;
							mod_etot = evict_total_q + 1'b1;
						end
					end
				end
				lrukr_pkg::OP_REMOVE: begin
					if (trk) begin
						if (!ce) begin
							mod_status = lrukr_pkg::ST_PINNED;
						end else begin
							mod_trk  = 1'b0;
							mod_ev   = 1'b0;
							mod_ttot = tracked_total_q - 1'b1;
							if (evict_total_q != '0) mod_etot = evict_total_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign mem_we = (state_q == S_MOD) && mod_we;

	// history class wins over cache class
	assign pick_any = hist.found || cache.found;
	assign pick_v   = hist.found ? hist.idx : cache.idx;

	// control state, flags and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			idx_q           <= '0;
			tracked_q       <= '0;
			evict_q         <= '0;
			tracked_total_q <= '0;
			evict_total_q   <= '0;
			stamp_q         <= '0;
			k_q             <= lrukr_pkg::K_RESET;
			fiu_q           <= lrukr_pkg::FIU_RESET;
			rsp_valid_q     <= 1'b0;
			vld_s1          <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					lrukr_pkg::CFG_K_VALUE:       k_q   <= cfg_data[lrukr_pkg::K_W-1:0];
					lrukr_pkg::CFG_FRAMES_IN_USE: fiu_q <= cfg_data;
					default: ;
				endcase
			end

			// output register handshake
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			vld_s1 <= (state_q == S_SCAN);

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= (req.op == lrukr_pkg::OP_EVICT) ? S_SCAN : S_MOD;
					end
				end
				S_MOD: begin
					tracked_q[req_q.frame] <= mod_trk;
					evict_q[req_q.frame]   <= mod_ev;
					tracked_total_q        <= mod_ttot;
					evict_total_q          <= mod_etot;
					if (mod_adv && (stamp_q != lrukr_pkg::STAMP_MAX)) begin
						stamp_q <= stamp_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (idx_q == LAST_FRAME) begin
						state_q <= S_SCAN_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN_LAST: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (pick_any) begin
						tracked_q[pick_v] <= 1'b0;
						evict_q[pick_v]   <= 1'b0;
						tracked_total_q   <= tracked_total_q - 1'b1;
						if (evict_total_q != '0) evict_total_q <= evict_total_q - 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= idx_q;
		if (state_q == S_MOD) begin
			res_q.status          <= mod_status;
			res_q.victim          <= '0;
			res_q.evictable_count <= mod_etot;
		end else if (state_q == S_PICK) begin
			if (pick_any) begin
				res_q.status <= lrukr_pkg::ST_OK;
				res_q.victim <= pick_v;
				res_q.evictable_count <= (evict_total_q != '0) ?
					evict_total_q - 1'b1 : evict_total_q;
			end else begin
				res_q.status          <= lrukr_pkg::ST_NONE;
				res_q.victim          <= '0;
				res_q.evictable_count <= evict_total_q;
			end
		end
		if ((state_q == S_RESP) && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ src/lrukr_frame_store.sv @@
module lrukr_frame_store (
	input  logic                               clk,
	input  logic                               we,
	input  logic [lrukr_pkg::FRAME_W-1:0]      waddr,
	input  lrukr_pkg::entry_t                  wdata,
	input  logic [lrukr_pkg::FRAME_W-1:0]      raddr,
	output lrukr_pkg::entry_t                  rdata
);

	lrukr_pkg::entry_t mem [lrukr_pkg::FRAME_SLOTS];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ src/lrukr_victim_sel.sv @@
module lrukr_victim_sel (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lrukr_pkg::scan_entry_t ent,
	output lrukr_pkg::pick_t       hist,
	output lrukr_pkg::pick_t       cache
);

	logic                          hist_found_q, cache_found_q;
	logic [lrukr_pkg::FRAME_W-1:0] hist_idx_q, cache_idx_q;
	logic [lrukr_pkg::STAMP_W-1:0] hist_stamp_q, cache_stamp_q;
	logic                          take_hist, take_cache;

	// strict compare keeps the lowest frame number on equal stamps
	assign take_hist  = ent.valid && ent.eligible && !ent.in_cache &&
		(!hist_found_q || (ent.stamp < hist_stamp_q));
	assign take_cache = ent.valid && ent.eligible && ent.in_cache &&
		(!cache_found_q || (ent.stamp < cache_stamp_q));

	// found flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_found_q  <= 1'b0;
			cache_found_q <= 1'b0;
		end else if (ent.clear) begin
			hist_found_q  <= 1'b0;
			cache_found_q <= 1'b0;
		end else begin
			if (take_hist)  hist_found_q  <= 1'b1;
			if (take_cache) cache_found_q <= 1'b1;
		end
	end

	// best candidate of each class
	always_ff @(posedge clk) begin
		if (take_hist && !ent.clear) begin
			hist_idx_q   <= ent.idx;
			hist_stamp_q <= ent.stamp;
		end
		if (take_cache && !ent.clear) begin
			cache_idx_q   <= ent.idx;
			cache_stamp_q <= ent.stamp;
		end
	end

	assign hist.found  = hist_found_q;
	assign hist.idx    = hist_idx_q;
	assign cache.found = cache_found_q;
	assign cache.idx   = cache_idx_q;

endmodule
